FILE: design/lpc_pkg.sv
// Shared types and constants for the LPC autocorrelation analysis block.
package lpc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned ORDER_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned NORM_BITS = 24;
  localparam int unsigned FRAC_BITS = 27;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SILENT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW = 2'd2;

  // Frame-end job handed from the front to the back.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ORDER_W-1:0]  order;
    logic [5:0]          shift;
  } lpc_job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_LOAD, BK_DOT, BK_DIVIDE, BK_LAMBDA, BK_ENERGY_SQ,
    BK_ENERGY_MUL, BK_UPDATE, BK_EMIT
  } lpc_back_state_e;

endpackage

FILE: design/lpc_front.sv
// Front end: sample history, lag accumulators and frame-end classification.
module lpc_front #(
  parameter int unsigned MaxOrder = 16,
  parameter int unsigned FrameMax = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [lpc_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          frame_end_i,
  input  logic [lpc_pkg::ORDER_W-1:0]   order_i,
  input  logic                          back_busy_i,
  output logic                          job_valid_o,
  output lpc_pkg::lpc_job_t             job_o,
  output logic signed [lpc_pkg::SUM_W-1:0] lag_o [MaxOrder+1]
);
  import lpc_pkg::*;

  localparam int unsigned CntW = $clog2(FrameMax + 1);

  logic signed [SAMPLE_W-1:0] hist_q [MaxOrder];
  logic signed [SUM_W-1:0]    acc_q  [MaxOrder+1];
  logic [CntW-1:0]            seen_q;
  logic                       job_valid_q;
  lpc_job_t                   job_q;
  logic                       take;
  logic [CntW-1:0]            seen_new;
  logic [ORDER_W-1:0]         ord;
  logic [5:0]                 bits;
  logic signed [SUM_W-1:0]    lag0_new;

  assign take     = accept_i && (seen_q < CntW'(FrameMax));
  assign seen_new = take ? seen_q + 1'b1 : seen_q;
  assign lag0_new = take ? acc_q[0] + SUM_W'(32'(sample_i) * 32'(sample_i)) : acc_q[0];

  // Clamp the configured order.
  always_comb begin
    ord = order_i;
    if (ord == '0) ord = ORDER_W'(1);
    if (32'(ord) > MaxOrder) ord = ORDER_W'(MaxOrder);
  end

  // Bit length of the energy sum.
  always_comb begin
    bits = '0;
    for (int b = 0; b < SUM_W; b++) begin
      if (lag0_new[b]) bits = 6'(b + 1);
    end
  end

  // Accumulate lags and shift the history; clear at frame end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < MaxOrder; i++) hist_q[i] <= '0;
      for (int i = 0; i <= MaxOrder; i++) acc_q[i] <= '0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        seen_q <= '0;
        for (int i = 0; i < MaxOrder; i++) hist_q[i] <= '0;
        for (int i = 0; i <= MaxOrder; i++) acc_q[i] <= '0;
      end else if (take) begin
        seen_q <= seen_new;
        acc_q[0] <= lag0_new;
        for (int i = 1; i <= MaxOrder; i++)
          acc_q[i] <= acc_q[i] + SUM_W'(32'(sample_i) * 32'(hist_q[i-1]));
        for (int i = MaxOrder - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
        hist_q[0] <= sample_i;
      end
    end
  end

  // Latch the closed frame's sums for the back end.
  always_ff @(posedge clk_i) begin
    if (accept_i && frame_end_i) begin
      lag_o[0] <= lag0_new;
      for (int i = 1; i <= MaxOrder; i++)
        lag_o[i] <= take ? acc_q[i] + SUM_W'(32'(sample_i) * 32'(hist_q[i-1])) : acc_q[i];
    end
  end

  // Hold one job until the back end takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_q       <= '0;
    end else if (accept_i && frame_end_i) begin
      job_valid_q  <= 1'b1;
      job_q.order  <= ord;
      job_q.shift  <= (bits > 6'(NORM_BITS)) ? bits - 6'(NORM_BITS) : '0;
      if (32'(seen_new) < 32'(ord) + 1) job_q.status <= STATUS_TOO_FEW;
      else if (lag0_new == '0)           job_q.status <= STATUS_SILENT;
      else                               job_q.status <= STATUS_OK;
    end else if (job_valid_q && !back_busy_i) begin
      job_valid_q <= 1'b0;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;
endmodule

FILE: design/lpc_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
module lpc_divider #(
  parameter int unsigned Width = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Width-1:0] num_i,
  input  logic signed [Width-1:0] den_i,
  output logic                    done_o,
  output logic signed [Width-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, quo_q, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, neg_q, done_q;
  logic [Width:0]   trial;

  assign trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};

  // Restoring division on magnitudes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
        rem_q  <= '0;
        quo_q  <= num_i[Width-1] ? -num_i : num_i;
        den_q  <= den_i[Width-1] ? -den_i : den_i;
        neg_q  <= num_i[Width-1] ^ den_i[Width-1];
      end else if (busy_q) begin
        if (!trial[Width]) begin
          rem_q <= trial[Width-1:0];
          quo_q <= {quo_q[Width-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[Width-2:0], quo_q[Width-1]};
          quo_q <= {quo_q[Width-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

FILE: design/lpc_back.sv
// Back end: Levinson-Durbin solve on a shared multiplier and result emission.
module lpc_back #(
  parameter int unsigned MaxOrder = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  lpc_pkg::lpc_job_t             job_i,
  input  logic signed [lpc_pkg::SUM_W-1:0] lag_i [MaxOrder+1],
  output logic                          busy_o,
  output logic                          valid_o,
  output logic signed [lpc_pkg::COEF_W-1:0] coefficient_o,
  output logic [lpc_pkg::ORDER_W-1:0]   coef_index_o,
  output logic [lpc_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);
  import lpc_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxOrder + 2);
  localparam logic signed [63:0] OneQ = 64'sd1 <<< FRAC_BITS;

  lpc_back_state_e state_q, state_d;
  lpc_job_t        job_q;
  logic signed [SUM_W-1:0] r_q [MaxOrder+1];
  logic signed [COEF_W-1:0] a_q [MaxOrder+2];
  logic signed [COEF_W-1:0] a_old_q [MaxOrder+2];
  logic signed [63:0] num_q, e_q, lam_q, l2_q;
  logic [IdxW-1:0] k_q, i_q;
  logic            div_start, div_done;
  logic signed [63:0] div_q;
  logic signed [63:0] prod;
  logic signed [31:0] ma, mb;
  logic signed [63:0] upd_u, upd_v, upd_sum;
  logic signed [63:0] e_new;

  // One shared 32x32 product: operands picked by state; normalized lags,
  // energy, lambda and coefficients all fit in 32 signed bits.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      BK_DOT:        begin ma = a_q[i_q]; mb = 32'(r_q[k_q + 1'b1 - i_q]); end
      BK_ENERGY_SQ:  begin ma = 32'(lam_q); mb = 32'(lam_q); end
      BK_ENERGY_MUL: begin ma = 32'(l2_q);  mb = 32'(e_q); end
      BK_UPDATE:     begin ma = 32'(lam_q); mb = 32'(upd_v); end
      default:       begin ma = '0; mb = '0; end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  // Update operands u and v for element i of step k.
  always_comb begin
    if (i_q == '0)            upd_u = OneQ;
    else if (i_q == k_q + 1'b1) upd_u = '0;
    else                      upd_u = 64'(a_old_q[i_q]);
    if (i_q == '0)            upd_v = '0;
    else if (i_q == k_q + 1'b1) upd_v = OneQ;
    else                      upd_v = 64'(a_old_q[k_q + 1'b1 - i_q]);
    upd_sum = upd_u + (prod >>> FRAC_BITS);
    e_new   = e_q - (prod >>> FRAC_BITS);
  end

  assign div_start = (state_q == BK_DOT) && (i_q == k_q);

  lpc_divider #(.Width(64)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q + prod),
    .den_i   (e_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (job_valid_i) state_d = BK_LOAD;
      BK_LOAD:   state_d = (job_q.status == STATUS_OK) ? BK_DOT : BK_EMIT;
      BK_DOT:    if (i_q == k_q) state_d = BK_DIVIDE;
      BK_DIVIDE: if (div_done) state_d = BK_LAMBDA;
      BK_LAMBDA: state_d = BK_ENERGY_SQ;
      BK_ENERGY_SQ:  state_d = BK_ENERGY_MUL;
      BK_ENERGY_MUL: state_d = BK_UPDATE;
      BK_UPDATE: if (i_q == k_q + 1'b1)
                   state_d = (k_q + 1'b1 == IdxW'(job_q.order)) ? BK_EMIT : BK_DOT;
      BK_EMIT:   if (job_q.status == STATUS_TOO_FEW || i_q == IdxW'(job_q.order))
                   state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: if (job_valid_i) begin
        job_q <= job_i;
        for (int j = 0; j <= MaxOrder; j++) r_q[j] <= lag_i[j] >>> job_i.shift;
      end
      BK_LOAD: begin
        a_q[0] <= COEF_W'(OneQ);
        e_q    <= 64'(r_q[0]);
        k_q    <= '0;
        i_q    <= (job_q.status == STATUS_OK) ? '0 : IdxW'(1);
        num_q  <= '0;
      end
      BK_DOT: begin
        num_q <= num_q + prod;
        if (i_q != k_q) i_q <= i_q + 1'b1;
      end
      BK_LAMBDA: begin
        if (-div_q > OneQ)       lam_q <= OneQ;
        else if (-div_q < -OneQ) lam_q <= -OneQ;
        else                     lam_q <= -div_q;
        for (int j = 0; j < MaxOrder + 2; j++) a_old_q[j] <= a_q[j];
      end
      BK_ENERGY_SQ: l2_q <= prod >>> FRAC_BITS;
      BK_ENERGY_MUL: begin
        e_q <= (e_new < 64'sd1) ? 64'sd1 : e_new;
        i_q <= '0;
      end
      BK_UPDATE: begin
        if (upd_sum > 64'sd2147483647)       a_q[i_q] <= 32'sh7fffffff;
        else if (upd_sum < -64'sd2147483648) a_q[i_q] <= 32'sh80000000;
        else                                 a_q[i_q] <= COEF_W'(upd_sum);
        if (i_q == k_q + 1'b1) begin
          k_q   <= k_q + 1'b1;
          i_q   <= (k_q + 1'b1 == IdxW'(job_q.order)) ? IdxW'(1) : '0;
          num_q <= '0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      BK_EMIT: i_q <= i_q + 1'b1;
      default: ;
    endcase
  end

  // Drive the result strobe from the emit state.
  always_comb begin
    valid_o       = (state_q == BK_EMIT);
    status_o      = job_q.status;
    coefficient_o = (job_q.status == STATUS_OK) ? a_q[i_q] : '0;
    coef_index_o  = (job_q.status == STATUS_TOO_FEW) ? '0 : ORDER_W'(i_q);
    last_o        = (job_q.status == STATUS_TOO_FEW) || (i_q == IdxW'(job_q.order));
    busy_o        = (state_q != BK_IDLE);
  end
endmodule

FILE: design/lpc_autocorrelation_analysis_top.sv
// Top level of the LPC autocorrelation analysis block.
// A sample transfers at a rising edge with start high and busy low; the lag
// sums for all lags accumulate in parallel, one sample a cycle. The sample
// with frame_end_i closes the frame and hands a job to the back end, which
// solves Levinson-Durbin on one shared 32x32 multiplier and a one-bit-a-cycle
// 64-bit divider. Step k of the solve runs a dot product, a divide, a lambda
// clamp, an energy square and multiply, and the update of a[0..k+1]; a silent
// or too-few frame skips the solve and goes from load straight to emission.
// Results then appear on valid_o one a cycle and cannot be stalled, so the
// receiver must take every strobe. busy is high from the closing edge until
// the back end takes the job: one cycle when the back end is idle, otherwise
// until the previous frame's last result has gone out; samples of the next
// frame wait meanwhile.
module lpc_autocorrelation_analysis_top #(
  parameter int unsigned ORDER_CAP = 16,
  parameter int unsigned FRAME_MAX = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lpc_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                frame_end_i,
  input  logic                                order_we_i,
  input  logic [lpc_pkg::ORDER_W-1:0]         order_wdata_i,
  output logic                                valid_o,
  output logic signed [lpc_pkg::COEF_W-1:0]   coefficient_o,
  output logic [lpc_pkg::ORDER_W-1:0]         coef_index_o,
  output logic [lpc_pkg::STATUS_W-1:0]        status_o,
  output logic                                last_o
);
  import lpc_pkg::*;

  logic [ORDER_W-1:0] order_q;
  logic               job_valid, back_busy, accept;
  lpc_job_t           job;
  logic signed [SUM_W-1:0] lag [ORDER_CAP+1];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         order_q <= ORDER_W'(10);
    else if (order_we_i) order_q <= order_wdata_i;
  end

  // Hold samples off while a closed frame waits for the back end.
  assign busy   = job_valid;
  assign accept = start && !busy;

  lpc_front #(.MaxOrder(ORDER_CAP), .FrameMax(FRAME_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .order_i     (order_q),
    .back_busy_i (back_busy),
    .job_valid_o (job_valid),
    .job_o       (job),
    .lag_o       (lag)
  );

  lpc_back #(.MaxOrder(ORDER_CAP)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .lag_i         (lag),
    .busy_o        (back_busy),
    .valid_o       (valid_o),
    .coefficient_o (coefficient_o),
    .coef_index_o  (coef_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );
endmodule

FILE: tb/lpc_autocorrelation_analysis_top_test.sv
// Self-checking testbench for the LPC autocorrelation analysis block.
module lpc_autocorrelation_analysis_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam int ORDER_CAP = 16;
  localparam int FRAME_MAX = 4096;
  localparam int TARGET_ITEMS = 320;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } sample_item_t;

  typedef struct {
    logic signed [COEF_W-1:0] coefficient;
    logic [ORDER_W-1:0]       coef_index;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } coef_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic frame_end_i = 1'b0;
  logic order_we_i = 1'b0;
  logic [ORDER_W-1:0] order_wdata_i = '0;
  logic valid_o;
  logic signed [COEF_W-1:0] coefficient_o;
  logic [ORDER_W-1:0] coef_index_o;
  logic [STATUS_W-1:0] status_o;
  logic last_o;

  lpc_autocorrelation_analysis_top #(
    .ORDER_CAP(ORDER_CAP),
    .FRAME_MAX(FRAME_MAX)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .sample_i(sample_i),
    .frame_end_i(frame_end_i),
    .order_we_i(order_we_i),
    .order_wdata_i(order_wdata_i),
    .valid_o(valid_o),
    .coefficient_o(coefficient_o),
    .coef_index_o(coef_index_o),
    .status_o(status_o),
    .last_o(last_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow state of the block
  longint lag_acc[ORDER_CAP+1];
  longint recent[ORDER_CAP];
  int unsigned frame_count;
  logic [ORDER_W-1:0] order_shadow = 5'd10;

  sample_item_t pending_q[$];
  coef_result_t coef_expect_q[$];
  int unsigned queued_items;
  int unsigned taken_items;
  int unsigned error_count;
  bit gaps_on;

  function automatic longint sat_coef(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void push_coef(longint c, int idx, logic [STATUS_W-1:0] st, bit lst);
    coef_result_t res;
    res.coefficient = c[COEF_W-1:0];
    res.coef_index  = idx[ORDER_W-1:0];
    res.status      = st;
    res.last        = lst;
    coef_expect_q.push_back(res);
  endfunction

  // Fixed-point Levinson-Durbin on the normalized lag sums
  function automatic void solve_lpc(int n);
    longint r[ORDER_CAP+1];
    longint a[ORDER_CAP+2];
    longint u[ORDER_CAP+2];
    longint v[ORDER_CAP+2];
    longint num, lam, l2, e, one_q;
    longint unsigned mag;
    int bits, sh;
    one_q = longint'(1) << FRAC_BITS;
    bits = 0;
    mag = lag_acc[0];
    while (mag != 0) begin
      bits++;
      mag = mag >> 1;
    end
    sh = (bits > NORM_BITS) ? bits - NORM_BITS : 0;
    for (int i = 0; i <= ORDER_CAP; i++) r[i] = lag_acc[i] >>> sh;
    for (int i = 0; i < ORDER_CAP + 2; i++) a[i] = 0;
    a[0] = one_q;
    e = r[0];
    for (int k = 0; k < n; k++) begin
      num = 0;
      for (int i = 0; i <= k; i++) num += a[i] * r[k+1-i];
      lam = -(num / e);
      if (lam > one_q) lam = one_q;
      if (lam < -one_q) lam = -one_q;
      l2 = (lam * lam) >>> FRAC_BITS;
      e = e - ((l2 * e) >>> FRAC_BITS);
      if (e < 1) e = 1;
      u[0] = one_q;
      v[0] = 0;
      for (int i = 1; i <= k; i++) begin
        u[i] = a[i];
        v[i] = a[k+1-i];
      end
      u[k+1] = 0;
      v[k+1] = one_q;
      for (int i = 0; i <= k + 1; i++) a[i] = sat_coef(u[i] + ((lam * v[i]) >>> FRAC_BITS));
    end
    for (int i = 1; i <= n; i++) push_coef(a[i], i, STATUS_OK, i == n);
  endfunction

  // Accumulate one sample and predict the results at frame end
  function automatic void take_sample(sample_item_t it);
    longint x;
    int n;
    x = longint'(it.sample);
    if (frame_count < FRAME_MAX) begin
      lag_acc[0] += x * x;
      for (int i = 1; i <= ORDER_CAP; i++) lag_acc[i] += x * recent[i-1];
      for (int i = ORDER_CAP - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = x;
      frame_count++;
    end
    if (!it.frame_end) return;
    n = order_shadow;
    if (n < 1) n = 1;
    if (n > ORDER_CAP) n = ORDER_CAP;
    if (frame_count < n + 1) begin
      push_coef(0, 0, STATUS_TOO_FEW, 1'b1);
    end else if (lag_acc[0] == 0) begin
      for (int i = 1; i <= n; i++) push_coef(0, i, STATUS_SILENT, i == n);
    end else begin
      solve_lpc(n);
    end
    for (int i = 0; i <= ORDER_CAP; i++) lag_acc[i] = 0;
    for (int i = 0; i < ORDER_CAP; i++) recent[i] = 0;
    frame_count = 0;
  endfunction

  // Driver: present queued samples, with random gaps when gaps_on is set
  sample_item_t cur_item;
  int idle_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        take_sample(cur_item);
        taken_items++;
        idle_left = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          start <= 1'b1;
          sample_i <= cur_item.sample;
          frame_end_i <= cur_item.frame_end;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    coef_result_t want;
    if (rst_ni && valid_o) begin
      if (coef_expect_q.size() == 0) begin
        $error("unexpected result: coefficient %0d index %0d", coefficient_o, coef_index_o);
        error_count++;
      end else begin
        want = coef_expect_q.pop_front();
        if (coefficient_o !== want.coefficient) begin
          $error("coefficient expected %0d got %0d", want.coefficient, coefficient_o);
          error_count++;
        end
        if (coef_index_o !== want.coef_index) begin
          $error("coef_index expected %0d got %0d", want.coef_index, coef_index_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0d got %0d", want.status, status_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0d got %0d", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic add_sample(int x, bit fe);
    sample_item_t it;
    it.sample = x[SAMPLE_W-1:0];
    it.frame_end = fe;
    pending_q.push_back(it);
    queued_items++;
  endtask

  // Wait until every sample is taken and every result has arrived
  task automatic drain();
    while (taken_items != queued_items || coef_expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_order(int unsigned val);
    @(posedge clk_i);
    order_we_i <= 1'b1;
    order_wdata_i <= val[ORDER_W-1:0];
    order_shadow = val[ORDER_W-1:0];
    @(posedge clk_i);
    order_we_i <= 1'b0;
  endtask

  // Build one frame: 0 full-scale noise, 1 silent, 2 random walk, 3 small
  task automatic add_frame(int len, int kind);
    int w;
    int x;
    w = 0;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: x = int'($urandom_range(0, 65535)) - 32768;
        1: x = 0;
        2: begin
          w += int'($urandom_range(0, 4000)) - 2000;
          if (w > 32767) w = 32767;
          if (w < -32768) w = -32768;
          x = w;
        end
        default: x = int'($urandom_range(0, 6)) - 3;
      endcase
      add_sample(x, i == len - 1);
    end
  endtask

  initial begin
    int unsigned phase_orders[8] = '{16, 31, 0, 2, 17, 5, 1, 3};
    int unsigned ord, n, phase, len, pick;
    gaps_on = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset order, too few, silent, extremes
    add_sample(-32768, 0);
    add_sample(32767, 0);
    add_sample(0, 1);
    add_frame(11, 1);
    drain();
    set_order(1);
    add_sample(32767, 0);
    add_sample(-32768, 1);
    add_sample(-32768, 1);
    add_sample(-1, 0);
    add_sample(-1, 1);
    drain();
    set_order(0);
    add_sample(32767, 0);
    add_sample(32767, 1);
    drain();

    // Random phases at several orders
    phase = 0;
    while (queued_items < TARGET_ITEMS) begin
      ord = (phase < 8) ? phase_orders[phase] : $urandom_range(0, 31);
      set_order(ord);
      n = (ord < 1) ? 1 : (ord > ORDER_CAP ? ORDER_CAP : ord);
      gaps_on = phase % 3 != 1;
      for (int f = 0; f < 4; f++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) add_frame($urandom_range(1, n), $urandom_range(0, 2));
        else if (pick == 1) add_frame(n + 1 + $urandom_range(0, 8), 1);
        else add_frame(n + 1 + $urandom_range(0, 24), pick % 4);
      end
      drain();
      phase++;
    end

    if (error_count == 0) begin
      $display("lpc_autocorrelation_analysis_top_test passed");
    end else begin
      $display("lpc_autocorrelation_analysis_top_test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("lpc_autocorrelation_analysis_top_test failed");
    $finish;
  end

endmodule
